// ===== rtl/dasp_pkg.sv =====
// Shared types, constants and the coil pattern tables for the two-axis stepper positioner.
// Used by dasp_axis and dual_axis_stepper_positioner; depends on nothing else.
package dasp_pkg;

	localparam int POS_BITS    = 16;
	localparam int PERIOD_BITS = 16;
	localparam int PADDR_BITS  = 3;

	typedef logic signed [POS_BITS-1:0] pos_t;
	typedef logic [PERIOD_BITS-1:0]     period_t;

	localparam pos_t POS_MAX     = pos_t'({1'b0, {(POS_BITS-1){1'b1}}});
	localparam pos_t POS_MIN     = pos_t'({1'b1, {(POS_BITS-1){1'b0}}});
	localparam pos_t POS_UNHOMED = pos_t'(-1);
	localparam pos_t POS_MOVING  = pos_t'(-2);

	localparam period_t STEP_PERIOD_RST = period_t'(36864);

	// Register index, taken from paddr[2].
	localparam logic REG_STEP_PERIOD = 1'b0;
	localparam logic REG_HALF_STEP   = 1'b1;

	typedef enum logic [2:0] {
		MODE_TICK = 3'd0,
		MODE_FWD  = 3'd1,
		MODE_BACK = 3'd2,
		MODE_STOP = 3'd3,
		MODE_MOVE = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BACK = 2'd2
	} dir_t;

	localparam logic [3:0] FULL_TAB [4] = '{4'hA, 4'h9, 4'h5, 4'h6};
	localparam logic [3:0] HALF_TAB [8] = '{4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2};

	// Control for one axis for the beat being accepted.
	typedef struct packed {
		logic       en;
		logic       step;
		logic       cmd;
		logic [2:0] mode;
		pos_t       target;
		logic       fwd_lim;
		logic       home_lim;
		logic       half_step;
	} axis_ctl_t;

	// Status of one axis: next coil drive and report, plus current run state.
	typedef struct packed {
		logic       running;
		logic       started;
		logic       busy;
		logic [3:0] coils;
		pos_t       report;
	} axis_sts_t;

	typedef struct packed {
		logic [3:0] pan_coils;
		logic [3:0] tilt_coils;
		pos_t       pan_report;
		pos_t       tilt_report;
		logic       cmd_busy;
	} result_t;

	function automatic logic [3:0] coil_pattern(input logic half, input logic [2:0] ph);
		logic [3:0] pat;
		if (half) begin
			pat = HALF_TAB[ph];
		end else begin
			pat = FULL_TAB[ph[1:0]];
		end
		return pat;
	endfunction

endpackage

// ===== rtl/dasp_axis.sv =====
// One stepper axis: phase, direction, position, goal and settled registers with
// the step and command update logic. Depends on dasp_pkg.
module dasp_axis (
	input  logic                clk,
	input  logic                arst_n,
	input  dasp_pkg::axis_ctl_t ctl,
	output dasp_pkg::axis_sts_t sts
);
	import dasp_pkg::*;

	logic [2:0] phase_q, phase_d;
	dir_t       run_q, run_d;
	dir_t       goal_dir_q, goal_dir_d;
	pos_t       pos_q, pos_d;
	pos_t       goal_q, goal_d;
	pos_t       settled_q, settled_d;
	logic [3:0] coil_q, coil_d;
	logic [2:0] ph, ph_n;
	logic       busy, started;

	always_comb begin
		phase_d    = phase_q;
		run_d      = run_q;
		goal_dir_d = goal_dir_q;
		pos_d      = pos_q;
		goal_d     = goal_q;
		settled_d  = settled_q;
		coil_d     = coil_q;
		busy       = 1'b0;
		started    = 1'b0;
		ph         = ctl.half_step ? phase_q : {1'b0, phase_q[1:0]};
		ph_n       = ph;

		if (ctl.en && ctl.step) begin
			if (run_q != DIR_IDLE) begin
				coil_d = coil_pattern(ctl.half_step, ph);
				if (run_q == DIR_FWD) begin
					ph_n  = ph + 3'd1;
					pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + pos_t'(1);
				end else begin
					ph_n  = ph - 3'd1;
					pos_d = (pos_q == POS_MIN) ? pos_q : pos_q - pos_t'(1);
				end
				phase_d = ctl.half_step ? ph_n : {1'b0, ph_n[1:0]};
			end
			if ((run_q == DIR_FWD && ctl.fwd_lim) || (run_q == DIR_BACK && ctl.home_lim)) begin
				if (ctl.home_lim) begin
					pos_d = '0;
				end
				run_d      = DIR_IDLE;
				goal_dir_d = DIR_IDLE;
				coil_d     = '0;
				settled_d  = pos_d;
			end
			// A halt above already cleared the goal direction, so this cannot fire twice.
			if ((goal_dir_d == DIR_FWD && goal_q <= pos_d) ||
			    (goal_dir_d == DIR_BACK && goal_q >= pos_d)) begin
				run_d      = DIR_IDLE;
				goal_dir_d = DIR_IDLE;
				coil_d     = '0;
				settled_d  = pos_d;
			end
		end else if (ctl.en && ctl.cmd) begin
			unique case (ctl.mode)
				MODE_FWD, MODE_BACK: begin
					if (settled_q != POS_UNHOMED) begin
						settled_d = POS_MOVING;
					end
					run_d   = (ctl.mode == MODE_FWD) ? DIR_FWD : DIR_BACK;
					started = 1'b1;
				end
				MODE_STOP: begin
					if (settled_q != POS_UNHOMED) begin
						run_d     = DIR_IDLE;
						coil_d    = '0;
						settled_d = pos_q;
					end else begin
						busy = 1'b1;
					end
				end
				MODE_MOVE: begin
					goal_d = ctl.target;
					if (settled_q == POS_MOVING) begin
						busy = 1'b1;
					end else if (settled_q != POS_UNHOMED) begin
						if (ctl.target != settled_q) begin
							run_d      = (ctl.target > settled_q) ? DIR_FWD : DIR_BACK;
							goal_dir_d = run_d;
							settled_d  = POS_MOVING;
							started    = 1'b1;
						end
					end else begin
						// Unhomed: seek the home switch first.
						run_d     = DIR_BACK;
						settled_d = POS_MOVING;
						started   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			run_q      <= DIR_IDLE;
			goal_dir_q <= DIR_IDLE;
			pos_q      <= POS_UNHOMED;
			goal_q     <= POS_UNHOMED;
			settled_q  <= POS_UNHOMED;
			coil_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			run_q      <= run_d;
			goal_dir_q <= goal_dir_d;
			pos_q      <= pos_d;
			goal_q     <= goal_d;
			settled_q  <= settled_d;
			coil_q     <= coil_d;
		end
	end

	assign sts.running = (run_q != DIR_IDLE);
	assign sts.started = started;
	assign sts.busy    = busy;
	assign sts.coils   = coil_d;
	assign sts.report  = settled_d;

endmodule

// ===== rtl/dual_axis_stepper_positioner.sv =====
// Top level of the two-axis stepper positioner: APB register file, step divider,
// two dasp_axis instances and a two-entry result queue. Depends on dasp_pkg and dasp_axis.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------------
//   command  | cmd_valid / cmd_ready | mode, axis, target, four limit switches
//   result   | res_valid / res_ready | pan_coils, tilt_coils, pan_report, tilt_report,
//            |                       | cmd_busy
//   config   | psel, penable, pwrite | paddr, pwdata, prdata (step_period, half_step)
//
// Each beat updates the axis state in the cycle it is accepted; its result is
// registered into the result queue, and one beat per cycle is sustained while res_ready is high.
// The result side holds two entries; cmd_ready drops only when both are full.
// Reset clears the divider, sets both axes unhomed and idle with coils off,
// and loads step_period 36864 and full-step mode.
module dual_axis_stepper_positioner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dasp_pkg::PADDR_BITS-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [2:0]                          mode,
	input  logic                                axis,
	input  dasp_pkg::pos_t                      target,
	input  logic                                pan_fwd_limit,
	input  logic                                pan_home_limit,
	input  logic                                tilt_fwd_limit,
	input  logic                                tilt_home_limit,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [3:0]                          pan_coils,
	output logic [3:0]                          tilt_coils,
	output dasp_pkg::pos_t                      pan_report,
	output dasp_pkg::pos_t                      tilt_report,
	output logic                                cmd_busy
);
	import dasp_pkg::*;

	period_t        step_period_q;
	logic           half_step_q;
	period_t        div_q, div_d;
	logic [PERIOD_BITS:0] div_next;
	period_t        period_eff;
	logic           accept, is_tick, wrap, cfg_wr;
	axis_ctl_t      pan_ctl, tilt_ctl;
	axis_sts_t      pan_sts, tilt_sts;
	result_t        res_new, head_q, skid_q;
	logic           head_vld_q, skid_vld_q, pop;

	// Configuration registers.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= STEP_PERIOD_RST;
			half_step_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_STEP_PERIOD: step_period_q <= pwdata[PERIOD_BITS-1:0];
				REG_HALF_STEP:   half_step_q   <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_STEP_PERIOD: prdata = 32'(step_period_q);
			REG_HALF_STEP:   prdata = 32'(half_step_q);
		endcase
	end

	// Step divider. A period of zero steps on every tick.
	assign accept     = cmd_valid && cmd_ready;
	assign is_tick    = (mode == MODE_TICK);
	assign period_eff = (step_period_q == '0) ? period_t'(1) : step_period_q;
	assign div_next   = {1'b0, div_q} + {{PERIOD_BITS{1'b0}}, 1'b1};
	assign wrap       = (div_next >= {1'b0, period_eff});

	always_comb begin
		div_d = div_q;
		if (accept && is_tick) begin
			div_d = wrap ? '0 : div_next[PERIOD_BITS-1:0];
		end
		// Motion starting from all-idle restarts the step period.
		if (accept && (pan_sts.started || tilt_sts.started) &&
		    !pan_sts.running && !tilt_sts.running) begin
			div_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
		end else begin
			div_q <= div_d;
		end
	end

	always_comb begin
		pan_ctl.en        = accept;
		pan_ctl.step      = is_tick && wrap;
		pan_ctl.cmd       = !is_tick && (axis == 1'b0);
		pan_ctl.mode      = mode;
		pan_ctl.target    = target;
		pan_ctl.fwd_lim   = pan_fwd_limit;
		pan_ctl.home_lim  = pan_home_limit;
		pan_ctl.half_step = half_step_q;

		tilt_ctl           = pan_ctl;
		tilt_ctl.cmd       = !is_tick && (axis == 1'b1);
		tilt_ctl.fwd_lim   = tilt_fwd_limit;
		tilt_ctl.home_lim  = tilt_home_limit;
	end

	dasp_axis u_pan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pan_ctl),
		.sts    (pan_sts)
	);

	dasp_axis u_tilt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tilt_ctl),
		.sts    (tilt_sts)
	);

	// Result queue: head register plus one skid entry.
	always_comb begin
		res_new.pan_coils   = pan_sts.coils;
		res_new.tilt_coils  = tilt_sts.coils;
		res_new.pan_report  = pan_sts.report;
		res_new.tilt_report = tilt_sts.report;
		res_new.cmd_busy    = pan_sts.busy || tilt_sts.busy;
	end

	assign cmd_ready = !skid_vld_q;
	assign pop       = head_vld_q && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop && skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else if (pop) begin
				head_vld_q <= accept;
			end else if (accept) begin
				if (head_vld_q) begin
					skid_vld_q <= 1'b1;
				end else begin
					head_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			head_q <= skid_q;
		end else if (accept && (pop || !head_vld_q)) begin
			head_q <= res_new;
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign res_valid   = head_vld_q;
	assign pan_coils   = head_q.pan_coils;
	assign tilt_coils  = head_q.tilt_coils;
	assign pan_report  = head_q.pan_report;
	assign tilt_report = head_q.tilt_report;
	assign cmd_busy    = head_q.cmd_busy;

endmodule
